[hdl/rau_pkg.sv]
// Package for the rational arithmetic unit: command, status and order codes,
// sequencer state type. No dependencies.
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4,
    CMD_NEG = 3'd5,
    CMD_ABS = 3'd6,
    CMD_TRUNC = 3'd7
  } cmd_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_GEVEN,
    ST_GODD,
    ST_GLOOP,
    ST_GSHL,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_e;

endpackage

[hdl/rau_divider.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing; used by the rational arithmetic unit top level.
module rau_divider #(
  parameter int W = 66
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [W:0]    trial;

  // one shift-subtract step
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: operand capture, shared multiplier,
// binary GCD sequencer and divider. Depends on rau_pkg and rau_divider.
//
// Usage: drive the operands and cmd_i, pulse start_i while busy_o is low.
// The beat is taken at that edge; busy_o stays high until the result is
// shown. The result appears on the result ports for one cycle with done_o
// high; the receiver cannot stall it, so it must take it then. A new beat
// may be taken in that same cycle.
// A zero denominator given is caught in ST_MUL1 and ends the beat. Every
// other beat runs the shared WIDTH x WIDTH multiplier in ST_MUL1 to ST_MUL3;
// compare is then decided in ST_COMB. The others go on to a binary GCD over
// 2*WIDTH+2 bit values (one shift or one subtract per cycle), then two
// divisions by the GCD on the bit-serial divider, each a start, 2*WIDTH+2
// shift-subtract steps and a handoff. Truncate skips the GCD; for the others
// the run time is set by the GCD loop and the divider.
// One beat is worked on at a time. Reset clears the sequencer to idle;
// no state survives between beats.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [2:0]       cmd_i,
  input  logic             a_sign_i,
  input  logic [WIDTH-1:0] a_numerator_i,
  input  logic [WIDTH-1:0] a_denominator_i,
  input  logic             b_sign_i,
  input  logic [WIDTH-1:0] b_numerator_i,
  input  logic [WIDTH-1:0] b_denominator_i,
  output logic             done_o,
  output logic             r_sign_o,
  output logic [WIDTH-1:0] r_numerator_o,
  output logic [WIDTH-1:0] r_denominator_o,
  output logic [1:0]       order_o,
  output logic [1:0]       status_o
);

  localparam int BW = 2 * WIDTH + 2;
  localparam int KW = $clog2(BW + 1);

  state_e state_q, state_d;

  cmd_e             cmd_q, cmd_d;
  logic             sa_q, sa_d, sb_q, sb_d;
  logic [WIDTH-1:0] na_q, na_d, da_q, da_d, nb_q, nb_d, db_q, db_d;
  logic [BW-1:0]    x_q, x_d, y_q, y_d, z_q, z_d;   // products
  logic [BW-1:0]    n_q, n_d, d_q, d_d;             // unreduced fraction
  logic [BW-1:0]    u_q, u_d, v_q, v_d;             // gcd operands
  logic [KW-1:0]    k_q, k_d;
  logic             rs_q, rs_d;
  logic [WIDTH-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [1:0]       ord_q, ord_d, st_q, st_d;
  logic             done_q, done_d;

  // shared multiplier
  logic [WIDTH-1:0]   m_a, m_b;
  logic [2*WIDTH-1:0] m_p;
  assign m_p = m_a * m_b;

  // shared compare / subtract
  logic [BW-1:0] s_a, s_b, s_diff;
  logic          s_lt;
  assign s_diff = s_a - s_b;
  assign s_lt   = s_a < s_b;

  logic          dv_start, dv_done;
  logic [BW-1:0] dv_num, dv_quot;

  rau_divider #(.W(BW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (u_q),
    .done_o (dv_done),
    .quot_o (dv_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; sa_d = sa_q; sb_d = sb_q;
    na_d = na_q; da_d = da_q; nb_d = nb_q; db_d = db_q;
    x_d = x_q; y_d = y_q; z_d = z_q; n_d = n_q; d_d = d_q;
    u_d = u_q; v_d = v_q; k_d = k_q;
    rs_d = rs_q; rn_d = rn_q; rd_d = rd_q; ord_d = ord_q; st_d = st_q;
    done_d = 1'b0;
    m_a = na_q; m_b = db_q;
    s_a = x_q; s_b = y_q;
    dv_start = 1'b0;
    dv_num = n_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_e'(cmd_i);
          na_d = a_numerator_i; da_d = a_denominator_i;
          nb_d = b_numerator_i; db_d = b_denominator_i;
          sa_d = a_sign_i & (a_numerator_i != '0);
          sb_d = b_sign_i & (b_numerator_i != '0);
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (da_q == '0 || (cmd_q <= CMD_CMP && db_q == '0)) begin
          rs_d = 1'b0; rn_d = '0; rd_d = WIDTH'(1);
          ord_d = ORD_LESS; st_d = STAT_ZDEN;
          state_d = ST_DONE;
        end else begin
          if (cmd_q == CMD_SUB && nb_q != '0) sb_d = ~sb_q;
          unique case (cmd_q)
            CMD_MUL: begin m_a = na_q; m_b = nb_q; end
            CMD_DIV: begin m_a = na_q; m_b = db_q; end
            default: begin m_a = na_q; m_b = db_q; end
          endcase
          x_d = BW'(m_p);
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        m_a = nb_q; m_b = da_q;
        y_d = BW'(m_p);
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        m_a = da_q; m_b = (cmd_q == CMD_DIV) ? nb_q : db_q;
        z_d = BW'(m_p);
        state_d = ST_COMB;
      end
      ST_COMB: begin
        s_a = x_q; s_b = y_q;
        ord_d = ORD_LESS; st_d = STAT_OK;
        rs_d = sa_q;
        unique case (cmd_q)
          CMD_ADD, CMD_SUB: begin
            if (sa_q == sb_q) begin
              n_d = x_q + y_q;
            end else if (!s_lt) begin
              n_d = s_diff;
            end else begin
              n_d = y_q - x_q; rs_d = sb_q;
            end
            d_d = z_q;
          end
          CMD_MUL: begin n_d = x_q; d_d = z_q; rs_d = sa_q ^ sb_q; end
          CMD_DIV: begin
            n_d = x_q; d_d = BW'(m_p); rs_d = sa_q ^ sb_q;
            // divisor product is da*nb, already in y_q
            d_d = y_q;
          end
          CMD_NEG: begin n_d = BW'(na_q); d_d = BW'(da_q); rs_d = ~sa_q; end
          CMD_ABS: begin n_d = BW'(na_q); d_d = BW'(da_q); rs_d = 1'b0; end
          CMD_TRUNC: begin n_d = BW'(na_q); d_d = BW'(da_q); end
          default: begin n_d = '0; d_d = BW'(1); end
        endcase
        if (cmd_q == CMD_CMP) begin
          rs_d = 1'b0; rn_d = '0; rd_d = WIDTH'(1);
          if (sa_q != sb_q) ord_d = sa_q ? ORD_LESS : ORD_GREATER;
          else if (x_q == y_q) ord_d = ORD_EQUAL;
          else ord_d = (s_lt ^ sa_q) ? ORD_LESS : ORD_GREATER;
          state_d = ST_DONE;
        end else if (cmd_q == CMD_TRUNC) begin
          // integer part: divide na by da on the divider
          u_d = BW'(da_q);
          state_d = ST_DIVN;
          dv_start = 1'b0;
        end else begin
          state_d = ST_GEVEN;
        end
        k_d = '0;
      end
      ST_GEVEN: begin
        // zero operands and the common power of two
        if (d_q == '0) begin
          rs_d = 1'b0; rn_d = '0; rd_d = WIDTH'(1);
          st_d = STAT_ZDEN; state_d = ST_DONE;
        end else if (n_q == '0) begin
          u_d = d_q; state_d = ST_DIVN;
        end else if (k_q == '0 && u_q != n_q) begin
          u_d = n_q; v_d = d_q; k_d = KW'(1);
        end else if (((u_q[0] | v_q[0]) == 1'b0)) begin
          u_d = u_q >> 1; v_d = v_q >> 1; k_d = k_q + 1'b1;
        end else begin
          state_d = ST_GODD;
        end
        if (k_q == '0 && n_q != '0 && d_q != '0) begin
          u_d = n_q; v_d = d_q; k_d = KW'(1); state_d = ST_GEVEN;
        end
      end
      ST_GODD: begin
        if (!u_q[0]) u_d = u_q >> 1;
        else state_d = ST_GLOOP;
      end
      ST_GLOOP: begin
        s_a = v_q; s_b = u_q;
        if (v_q == '0) begin
          state_d = ST_GSHL;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (s_lt) begin
          u_d = v_q; v_d = u_q - v_q;
        end else begin
          v_d = s_diff;
        end
      end
      ST_GSHL: begin
        if (k_q > KW'(1)) begin
          u_d = u_q << 1; k_d = k_q - 1'b1;
        end else begin
          state_d = ST_DIVN;
        end
      end
      ST_DIVN: begin
        // first pass divides n, second d; flag in k_q
        if (k_q != '1) begin
          dv_num = n_q; dv_start = 1'b1; k_d = '1;
        end else if (dv_done) begin
          n_d = dv_quot;
          if (cmd_q == CMD_TRUNC) begin
            d_d = BW'(1); u_d = BW'(1);
          end
          state_d = ST_DIVD;
          k_d = '0;
        end
      end
      ST_DIVD: begin
        if (k_q != '1) begin
          dv_num = d_q; dv_start = 1'b1; k_d = '1;
        end else if (dv_done) begin
          ord_d = ORD_LESS;
          if (n_q[BW-1:WIDTH] != '0 || dv_quot[BW-1:WIDTH] != '0) begin
            rs_d = 1'b0; rn_d = '0; rd_d = WIDTH'(1); st_d = STAT_OVF;
          end else begin
            rs_d = rs_q & (n_q != '0);
            rn_d = n_q[WIDTH-1:0]; rd_d = dv_quot[WIDTH-1:0]; st_d = STAT_OK;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; sa_q <= sa_d; sb_q <= sb_d;
    na_q <= na_d; da_q <= da_d; nb_q <= nb_d; db_q <= db_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d; n_q <= n_d; d_q <= d_d;
    u_q <= u_d; v_q <= v_d;
    rs_q <= rs_d; rn_q <= rn_d; rd_q <= rd_d; ord_q <= ord_d; st_q <= st_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign r_sign_o        = rs_q;
  assign r_numerator_o   = rn_q;
  assign r_denominator_o = rd_q;
  assign order_o         = ord_q;
  assign status_o        = st_q;

endmodule
